// File: rtl/core/cde_pkg.sv
// Package for the comb delay effect: field widths, register indexes and
// the percent to Q15 gain conversion. No dependencies.
package cde_pkg;

  localparam int unsigned SampleW      = 16;
  localparam int unsigned PctW         = 8;
  localparam int unsigned DelayMsW     = 10;
  localparam int unsigned GainW        = 17;
  localparam int unsigned QShift       = 15;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned CfgDataW     = 10;
  localparam int unsigned DefDepth     = 32768;
  localparam int unsigned DefSampPerMs = 48;

  localparam logic [CfgIdxW-1:0] REG_DELAY_MS    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_FEEDFORWARD = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_BLEND       = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_FEEDBACK    = CfgIdxW'(3);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [GainW-1:0]   gain_t;

  // q = pct * 32767 / 100, truncated toward zero.
  // |pct| * 32767 = |pct| * 327 * 100 + |pct| * 67; the tail is divided by
  // 100 through the reciprocal 5243 / 2^19, exact for |pct| * 67 <= 8576.
  function automatic gain_t gain_q15(input logic [PctW-1:0] pct);
    logic [PctW-1:0] mag;
    logic [13:0]     tail;
    logic [26:0]     recip;
    logic [15:0]     qmag;
    mag   = pct[PctW-1] ? PctW'(-pct) : pct;
    tail  = 14'(mag) * 14'd67;
    recip = 27'(tail) * 27'd5243;
    qmag  = 16'(mag) * 16'd327 + 16'(recip[26:19]);
    return pct[PctW-1] ? -gain_t'({1'b0, qmag}) : gain_t'({1'b0, qmag});
  endfunction

endpackage

// File: rtl/core/cde_if.sv
// Handshake channels of the comb delay effect: input samples, output
// samples and configuration writes. Depends on cde_pkg.
interface cde_in_if;
  import cde_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cde_out_if;
  import cde_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface cde_cfg_if;
  import cde_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/comb_delay_effect.sv
// Comb delay effect: ring buffer delay with feedforward, blend and feedback.
// Depends on cde_pkg and the channel interfaces in cde_if.sv.
// Channel  Port    Dir  Payload
// input    in_i    in   sample_in  (16 bit signed)
// output   out_o   out  sample_out (16 bit signed)
// config   cfg_i   in   index (8 bit), data (10 bit)
// Each item passes through accept with ring read, two multiply steps around
// the feedback add, then write-back; a new item is taken only in idle, after
// the write-back of the last one. The next item is taken while the
// result waits in the output register; write-back holds while it is full.
// Reset clears control and index at once; ring entries at or above the fill
// count read as zero, so no clearing pass is needed. Config is always ready.
module comb_delay_effect #(
  parameter int unsigned DEPTH          = cde_pkg::DefDepth,
  parameter int unsigned SAMPLES_PER_MS = cde_pkg::DefSampPerMs
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cde_in_if.sink    in_i,
  cde_out_if.source out_o,
  cde_cfg_if.sink   cfg_i
);
  import cde_pkg::*;

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned LW  = $clog2(DEPTH + 1);
  localparam int unsigned MSW = DelayMsW + $clog2(SAMPLES_PER_MS + 1);
  localparam int unsigned CW  = (MSW > LW) ? MSW : LW;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_WB   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SampleW-1:0] ring_mem [DEPTH];
  logic [SampleW-1:0] rd_data_q;
  logic               rd_hit_q;

  logic [IW-1:0] idx_q;
  logic [LW-1:0] fill_q;
  logic [LW-1:0] len_q;
  gain_t         gain_ff_q, gain_bl_q, gain_fb_q;

  sample_t x_q, ff_q, fb_q, s_q, bl_q;
  sample_t d, s_d, y;
  logic signed [GainW+SampleW-1:0] prod_ff, prod_fb, prod_bl;

  logic out_valid_q;
  sample_t out_sample_q;

  logic in_acc, wb_go;
  logic [LW-1:0] idx_next;
  logic [MSW-1:0] len_prod;
  logic [LW-1:0]  len_d;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.sample_out = out_sample_q;

  assign wb_go = (state_q == ST_WB) && (!out_valid_q || out_o.ready);

  assign d       = rd_hit_q ? sample_t'(rd_data_q) : '0;
  assign prod_ff = gain_ff_q * d;
  assign prod_fb = gain_fb_q * d;
  assign prod_bl = gain_bl_q * s_q;
  assign s_d     = x_q + fb_q;
  assign y       = ff_q + bl_q;

  assign idx_next = LW'(idx_q) + LW'(1);
  assign len_prod = MSW'(cfg_i.data[DelayMsW-1:0]) * MSW'(SAMPLES_PER_MS);

  always_comb begin
    if (len_prod == '0) begin
      len_d = LW'(1);
    end else if (CW'(len_prod) > CW'(DEPTH)) begin
      len_d = LW'(DEPTH);
    end else begin
      len_d = LW'(len_prod);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_SUM;
      ST_SUM:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_WB;
      ST_WB:   if (wb_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= ring_mem[idx_q];
    end
    if (wb_go) begin
      ring_mem[idx_q] <= y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q      <= in_i.sample_in;
      rd_hit_q <= LW'(idx_q) < fill_q;
    end
    if (state_q == ST_MUL1) begin
      ff_q <= prod_ff[QShift +: SampleW];
      fb_q <= prod_fb[QShift +: SampleW];
    end
    if (state_q == ST_SUM) begin
      s_q <= s_d;
    end
    if (state_q == ST_MUL2) begin
      bl_q <= prod_bl[QShift +: SampleW];
    end
    if (wb_go) begin
      out_sample_q <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wb_go) begin
        out_valid_q <= 1'b1;
        if (LW'(idx_q) == fill_q) begin
          fill_q <= fill_q + LW'(1);
        end
        if (idx_next >= len_q) begin
          idx_q <= '0;
        end else begin
          idx_q <= idx_next[IW-1:0];
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LW'(1);
      gain_ff_q <= '0;
      gain_bl_q <= '0;
      gain_fb_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DELAY_MS:    len_q     <= len_d;
        REG_FEEDFORWARD: gain_ff_q <= gain_q15(cfg_i.data[PctW-1:0]);
        REG_BLEND:       gain_bl_q <= gain_q15(cfg_i.data[PctW-1:0]);
        REG_FEEDBACK:    gain_fb_q <= gain_q15(cfg_i.data[PctW-1:0]);
        default: ;
      endcase
    end
  end

endmodule
